[src/assert_macros.svh]
// Assertion macros shared by the search block RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge out of reset.
`define ASSERT_AT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same-cycle implication.
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[src/lws_pkg.sv]
// Types and constants of the lookahead waypoint search block.
package lws_pkg;

	localparam int COORD_W   = 32;
	localparam int OP_W      = 2;
	localparam int STATUS_W  = 2;
	localparam int OUT_IDX_W = 10;
	localparam int LA_W      = 20;
	localparam int LD_W      = 2 * LA_W;
	localparam int SQ_W      = 2 * COORD_W;
	localparam int DIST_W    = SQ_W + 1;

	localparam logic [LA_W-1:0] LA_RESET = 20'd1024;

	typedef enum logic [OP_W-1:0] {
		OP_CLEAR  = 2'd0,
		OP_APPEND = 2'd1,
		OP_QUERY  = 2'd2
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		STAT_OK    = 2'd0,
		STAT_EMPTY = 2'd1,
		STAT_FULL  = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_MIN,
		S_AHEAD,
		S_RESP
	} state_t;

	// Control that travels with each point read through the distance pipe.
	typedef struct packed {
		logic vld;
		logic last;
	} scan_tag_t;

endpackage

[src/lws_ifs.sv]
// Request and response channel interfaces.
interface lws_req_if import lws_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic [OP_W-1:0]           opcode;
	logic signed [COORD_W-1:0] east;
	logic signed [COORD_W-1:0] north;

	modport source(output valid, output opcode, output east, output north, input ready);
	modport sink(input valid, input opcode, input east, input north, output ready);
endinterface

interface lws_rsp_if import lws_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [STATUS_W-1:0]  status;
	logic [OUT_IDX_W-1:0] waypoint_index;
	logic [OUT_IDX_W-1:0] closest_index;

	modport source(output valid, output status, output waypoint_index,
		output closest_index, input ready);
	modport sink(input valid, input status, input waypoint_index,
		input closest_index, output ready);
endinterface

[src/lookahead_waypoint_search.sv]
// Top level of the lookahead waypoint search block.
//
//  channel  dir  handshake         word
//  req      in   valid/ready       opcode, east, north
//  rsp      out  valid/ready       status, waypoint_index, closest_index
//  cfg      in   cfg_we            cfg_wdata (lookahead distance)
//
// Clear, append and unused opcodes go from accept through the response state to the held result word.
// A query over n points makes one memory read per cycle, first over the whole
// path, then from the closest point on, each pass drained through the 4-stage
// distance pipe.
// Reset clears the point count and the control; the point memory is not cleared.
// A held result does not block the next word; it stalls only the next result.
`include "assert_macros.svh"

module lookahead_waypoint_search import lws_pkg::*; #(
	parameter int PATH_DEPTH = 1024
) (
	input  logic             clk,
	input  logic             arst_n,
	lws_req_if.sink          req,
	lws_rsp_if.source        rsp,
	input  logic             cfg_we,
	input  logic [LA_W-1:0]  cfg_wdata
);

	localparam int IDX_W = $clog2(PATH_DEPTH);
	localparam int CNT_W = $clog2(PATH_DEPTH + 1);

	state_t                    state_q, state_d;
	logic [CNT_W-1:0]          count_q, cnt_m1;
	logic [IDX_W-1:0]          last_idx;
	logic [LA_W-1:0]           la_q;
	logic [LD_W-1:0]           ld_q;
	logic signed [COORD_W-1:0] pos_e_q, pos_n_q;
	logic [IDX_W-1:0]          rd_idx_q, best_q, tgt_q, best_nxt;
	logic [DIST_W-1:0]         best_d_q;
	logic                      issue_q, have_best_q, found_q;
	status_t                   res_status_q;
	logic                      rsp_valid_q;
	status_t                   rsp_status_q;
	logic [OUT_IDX_W-1:0]      rsp_wp_q, rsp_cl_q;
	logic [IDX_W+OUT_IDX_W-1:0] best_ext, tgt_ext;

	logic                      acc, full, rd_en, mem_we, rsp_load, best_upd;
	op_t                       op;
	scan_tag_t                 tag_in, tag_out;
	logic [IDX_W-1:0]          idx_out;
	logic [DIST_W-1:0]         dist_out;
	logic signed [COORD_W-1:0] rd_east, rd_north;

	assign op       = op_t'(req.opcode);
	assign acc      = req.valid && req.ready;
	assign full     = count_q >= CNT_W'(PATH_DEPTH);
	assign cnt_m1   = count_q - CNT_W'(1);
	assign last_idx = cnt_m1[IDX_W-1:0];
	assign best_upd = tag_out.vld && (!have_best_q || dist_out < best_d_q);
	assign best_nxt = best_upd ? idx_out : best_q;
	assign rsp_load = (state_q == S_RESP) && (!rsp_valid_q || rsp.ready);

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (acc) begin
					if (op == OP_QUERY && count_q != '0) begin
						state_d = S_MIN;
					end else begin
						state_d = S_RESP;
					end
				end
			end
			S_MIN: begin
				if (tag_out.vld && tag_out.last) begin
					state_d = S_AHEAD;
				end
			end
			S_AHEAD: begin
				if (tag_out.vld && tag_out.last) begin
					state_d = S_RESP;
				end
			end
			S_RESP: begin
				if (rsp_load) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Outputs of the state machine
	always_comb begin
		req.ready   = 1'b0;
		rd_en       = 1'b0;
		tag_in.vld  = 1'b0;
		tag_in.last = 1'b0;
		case (state_q)
			S_IDLE: req.ready = 1'b1;
			S_MIN, S_AHEAD: begin
				rd_en       = issue_q;
				tag_in.vld  = issue_q;
				tag_in.last = issue_q && (rd_idx_q == last_idx);
			end
			S_RESP: req.ready = 1'b0;
			default: req.ready = 1'b0;
		endcase
	end

	assign mem_we = acc && (op == OP_APPEND) && !full;

	// Lookahead register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			la_q <= LA_RESET;
		end else if (cfg_we) begin
			la_q <= cfg_wdata;
		end
	end

	// Control registers: state, count, scan issue
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			issue_q <= 1'b0;
			rd_idx_q <= '0;
		end else begin
			state_q <= state_d;
			if (acc && op == OP_CLEAR) begin
				count_q <= '0;
			end else if (mem_we) begin
				count_q <= count_q + CNT_W'(1);
			end
			if (acc && op == OP_QUERY && count_q != '0) begin
				issue_q  <= 1'b1;
				rd_idx_q <= '0;
			end else if (state_q == S_MIN && tag_out.vld && tag_out.last) begin
				// restart reads at the closest point
				issue_q  <= 1'b1;
				rd_idx_q <= best_nxt;
			end else if (rd_en) begin
				if (tag_in.last) begin
					issue_q <= 1'b0;
				end else begin
					rd_idx_q <= rd_idx_q + IDX_W'(1);
				end
			end
		end
	end

	// Search registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_best_q <= 1'b0;
			found_q     <= 1'b0;
		end else begin
			if (acc) begin
				have_best_q <= 1'b0;
				found_q     <= 1'b0;
			end else begin
				if (state_q == S_MIN && tag_out.vld) begin
					have_best_q <= 1'b1;
				end
				if (state_q == S_AHEAD && tag_out.vld && dist_out > DIST_W'(ld_q)) begin
					found_q <= 1'b1;
				end
			end
		end
	end

	// Search payload: query position, squared lookahead, status, best and target
	always_ff @(posedge clk) begin
		if (acc) begin
			pos_e_q      <= req.east;
			pos_n_q      <= req.north;
			ld_q         <= LD_W'(la_q) * LD_W'(la_q);
			best_q       <= '0;
			res_status_q <= STAT_OK;
			if (op == OP_QUERY && count_q != '0) begin
				tgt_q <= last_idx;
			end else begin
				tgt_q <= '0;
			end
			if (op == OP_QUERY && count_q == '0) begin
				res_status_q <= STAT_EMPTY;
			end else if (op == OP_APPEND && full) begin
				res_status_q <= STAT_FULL;
			end
		end else begin
			if (state_q == S_MIN && best_upd) begin
				best_q   <= idx_out;
				best_d_q <= dist_out;
			end
			if (state_q == S_AHEAD && tag_out.vld && !found_q
					&& dist_out > DIST_W'(ld_q)) begin
				tgt_q <= idx_out;
			end
		end
	end

	assign best_ext = {{OUT_IDX_W{1'b0}}, best_q};
	assign tgt_ext  = {{OUT_IDX_W{1'b0}}, tgt_q};

	// Hold the result word until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (rsp_load) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rsp_load) begin
			rsp_status_q <= res_status_q;
			rsp_wp_q     <= tgt_ext[OUT_IDX_W-1:0];
			rsp_cl_q     <= best_ext[OUT_IDX_W-1:0];
		end
	end

	assign rsp.valid          = rsp_valid_q;
	assign rsp.status         = rsp_status_q;
	assign rsp.waypoint_index = rsp_wp_q;
	assign rsp.closest_index  = rsp_cl_q;

	lws_path_mem #(
		.DEPTH(PATH_DEPTH)
	) u_mem (
		.clk        (clk),
		.we         (mem_we),
		.waddr      (count_q[IDX_W-1:0]),
		.wdata_east (req.east),
		.wdata_north(req.north),
		.re         (rd_en),
		.raddr      (rd_idx_q),
		.rdata_east (rd_east),
		.rdata_north(rd_north)
	);

	lws_dist_pipe #(
		.IDX_W(IDX_W)
	) u_dist (
		.clk      (clk),
		.arst_n   (arst_n),
		.tag_in   (tag_in),
		.idx_in   (rd_idx_q),
		.pt_east  (rd_east),
		.pt_north (rd_north),
		.pos_east (pos_e_q),
		.pos_north(pos_n_q),
		.tag_out  (tag_out),
		.idx_out  (idx_out),
		.dist_out (dist_out)
	);

	`ASSERT_AT(a_count_bound, clk, arst_n, count_q <= CNT_W'(PATH_DEPTH), "point count beyond depth")
	`ASSERT_IMPL(a_read_in_path, clk, arst_n, rd_en, rd_idx_q <= last_idx, "read past last point")
	`ASSERT_IMPL(a_dist_in_scan, clk, arst_n, tag_out.vld, state_q == S_MIN || state_q == S_AHEAD, "distance outside scan")
	`ASSERT_IMPL(a_target_order, clk, arst_n, state_q == S_RESP, tgt_q >= best_q, "target before closest point")
	`ASSERT_NEXT(a_min_to_ahead, clk, arst_n, state_q == S_MIN && tag_out.vld && tag_out.last, issue_q && rd_idx_q == best_q, "second pass not started at closest point")

endmodule

[src/lws_path_mem.sv]
// Path point memory: one write port, one registered read port.
module lws_path_mem import lws_pkg::*; #(
	parameter int DEPTH = 1024,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic                      clk,
	input  logic                      we,
	input  logic [AW-1:0]             waddr,
	input  logic signed [COORD_W-1:0] wdata_east,
	input  logic signed [COORD_W-1:0] wdata_north,
	input  logic                      re,
	input  logic [AW-1:0]             raddr,
	output logic signed [COORD_W-1:0] rdata_east,
	output logic signed [COORD_W-1:0] rdata_north
);

	logic [2*COORD_W-1:0] mem_q [DEPTH];

	// Store appended points
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= {wdata_east, wdata_north};
		end
	end

	// Read one point per cycle while re is set
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_east  <= mem_q[raddr][2*COORD_W-1:COORD_W];
			rdata_north <= mem_q[raddr][COORD_W-1:0];
		end
	end

endmodule

[src/lws_dist_pipe.sv]
// Squared distance pipeline: align, absolute difference, square, sum.
module lws_dist_pipe import lws_pkg::*; #(
	parameter int IDX_W = 10
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  scan_tag_t                 tag_in,
	input  logic [IDX_W-1:0]          idx_in,
	input  logic signed [COORD_W-1:0] pt_east,
	input  logic signed [COORD_W-1:0] pt_north,
	input  logic signed [COORD_W-1:0] pos_east,
	input  logic signed [COORD_W-1:0] pos_north,
	output scan_tag_t                 tag_out,
	output logic [IDX_W-1:0]          idx_out,
	output logic [DIST_W-1:0]         dist_out
);

	scan_tag_t          tag_s1, tag_s2, tag_s3, tag_s4;
	logic [IDX_W-1:0]   idx_s1, idx_s2, idx_s3, idx_s4;
	logic [COORD_W:0]   diff_e, diff_n, neg_e, neg_n;
	logic [COORD_W-1:0] mag_e_s2, mag_n_s2;
	logic [SQ_W-1:0]    sq_e_s3, sq_n_s3;
	logic [DIST_W-1:0]  dist_s4;

	// Advance the tags alongside the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '0;
			tag_s2 <= '0;
			tag_s3 <= '0;
			tag_s4 <= '0;
		end else begin
			tag_s1 <= tag_in;
			tag_s2 <= tag_s1;
			tag_s3 <= tag_s2;
			tag_s4 <= tag_s3;
		end
	end

	// Differences, sign-extended by one bit so they cannot overflow
	always_comb begin
		diff_e = {pt_east[COORD_W-1], pt_east} - {pos_east[COORD_W-1], pos_east};
		diff_n = {pt_north[COORD_W-1], pt_north} - {pos_north[COORD_W-1], pos_north};
		neg_e  = -diff_e;
		neg_n  = -diff_n;
	end

	// Magnitude, square, sum
	always_ff @(posedge clk) begin
		idx_s1   <= idx_in;
		idx_s2   <= idx_s1;
		idx_s3   <= idx_s2;
		idx_s4   <= idx_s3;
		mag_e_s2 <= diff_e[COORD_W] ? neg_e[COORD_W-1:0] : diff_e[COORD_W-1:0];
		mag_n_s2 <= diff_n[COORD_W] ? neg_n[COORD_W-1:0] : diff_n[COORD_W-1:0];
		sq_e_s3  <= SQ_W'(mag_e_s2) * SQ_W'(mag_e_s2);
		sq_n_s3  <= SQ_W'(mag_n_s2) * SQ_W'(mag_n_s2);
		dist_s4  <= DIST_W'(sq_e_s3) + DIST_W'(sq_n_s3);
	end

	assign tag_out  = tag_s4;
	assign idx_out  = idx_s4;
	assign dist_out = dist_s4;

endmodule
